// ===== hw/rtl/hdcl_pkg.sv =====
`timescale 1ns / 1ps

package hdcl_pkg;

  // default limits
  localparam int MAX_TOKENS_DEF  = 10;
  localparam int QUEUE_DEPTH_DEF = 4;

  // special characters
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_T       = 8'h54;

  // result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_IGNORE = 2'd2;

  // keyword progress once the whole keyword has matched
  localparam logic [2:0] KW_DONE = 3'd4;

  // event handed from the front to the back: up to two result words
  typedef struct packed {
    logic       has_data;
    logic [7:0] data_byte;
    logic [3:0] byte_index;
    logic       has_line;
    logic [1:0] line_kind;
    logic [3:0] frame_len;
  } ev_t;

  // hex digit value, non-hex characters give 0
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'd55;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'd87;
    return v[3:0];
  endfunction

  // characters of the keyword "DATA"
  function automatic logic [7:0] kw_char(input logic [1:0] p);
    logic [7:0] ch;
    unique case (p)
      2'd0: ch = CH_D;
      2'd1: ch = CH_A;
      2'd2: ch = CH_T;
      2'd3: ch = CH_A;
      default: ch = CH_A;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/hdcl_front.sv =====
`timescale 1ns / 1ps

module hdcl_front #(
  parameter int MAX_TOKENS = hdcl_pkg::MAX_TOKENS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               q_full,
  output logic               push,
  output hdcl_pkg::ev_t      push_ev
);

  localparam int TCW = $clog2(MAX_TOKENS + 1);

  logic [TCW-1:0] tc, tc_next;
  logic           in_tok, in_tok_next;
  logic [1:0]     cp, cp_next;
  logic [7:0]     acc, acc_next;
  logic [2:0]     kp, kp_next;
  logic           kf, kf_next;

  logic           accept;
  logic           is_nl;
  logic           is_sep;
  logic           start;
  logic [1:0]     cp_eff;
  logic [3:0]     nib;
  logic [2:0]     kp_try;
  logic [TCW+3:0] tc_ext;
  logic [TCW+3:0] idx_diff;
  logic [TCW+3:0] len_diff;

  // the queue sets the pace of the input side
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign is_nl  = (rx_byte == hdcl_pkg::CH_NEWLINE);
  assign is_sep = is_nl || (rx_byte == hdcl_pkg::CH_SPACE);
  assign nib    = hdcl_pkg::hex_nibble(rx_byte);

  // index and length are reported modulo 16
  assign tc_ext   = {4'b0, tc};
  assign idx_diff = tc_ext - (TCW+4)'(2);
  assign len_diff = tc_ext - (TCW+4)'(1);

  // classify the word and update line state
  always_comb begin
    tc_next     = tc;
    in_tok_next = in_tok;
    cp_next     = cp;
    acc_next    = acc;
    kp_next     = kp;
    kf_next     = kf;
    push_ev     = '0;
    start       = 1'b0;
    cp_eff      = cp;
    kp_try      = 3'd0;
    if (accept) begin
      if (is_sep) begin
        // a separator closes the current token
        if (in_tok && kf && (tc >= TCW'(2))) begin
          push_ev.has_data   = 1'b1;
          push_ev.data_byte  = acc;
          push_ev.byte_index = idx_diff[3:0];
        end
        in_tok_next = 1'b0;
        if (is_nl) begin
          push_ev.has_line = 1'b1;
          if (kf && (tc >= TCW'(1))) begin
            push_ev.line_kind = hdcl_pkg::KIND_ACCEPT;
            push_ev.frame_len = len_diff[3:0];
          end else begin
            push_ev.line_kind = hdcl_pkg::KIND_IGNORE;
          end
          tc_next  = '0;
          cp_next  = 2'd0;
          acc_next = 8'd0;
          kp_next  = 3'd0;
          kf_next  = 1'b0;
        end
      end else begin
        // token character, maybe opening a new token
        start = !in_tok && (tc < TCW'(MAX_TOKENS));
        if (start) begin
          tc_next     = tc + TCW'(1);
          in_tok_next = 1'b1;
          cp_eff      = 2'd0;
          acc_next    = 8'd0;
        end
        if (in_tok || start) begin
          if (tc_next == TCW'(1)) begin
            // keyword search inside the first token
            if (!kf) begin
              if (rx_byte == hdcl_pkg::kw_char(kp[1:0])) begin
                kp_try = {1'b0, kp[1:0]} + 3'd1;
              end else begin
                kp_try = (rx_byte == hdcl_pkg::CH_D) ? 3'd1 : 3'd0;
              end
              kp_next = kp_try;
              if (kp_try >= hdcl_pkg::KW_DONE) begin
                kf_next = 1'b1;
                kp_next = hdcl_pkg::KW_DONE;
              end
            end
          end else begin
            // hex decode of the first two characters
            unique case (cp_eff)
              2'd0:    acc_next = {nib, 4'b0};
              2'd1:    acc_next = acc | {4'b0, nib};
              default: acc_next = acc;
            endcase
          end
          cp_next = (cp_eff < 2'd2) ? cp_eff + 2'd1 : cp_eff;
        end
      end
    end
  end

  assign push = accept && (push_ev.has_data || push_ev.has_line);

  always_ff @(posedge clk) begin
    if (rst) begin
      tc     <= '0;
      in_tok <= 1'b0;
      cp     <= 2'd0;
      acc    <= 8'd0;
      kp     <= 3'd0;
      kf     <= 1'b0;
    end else begin
      tc     <= tc_next;
      in_tok <= in_tok_next;
      cp     <= cp_next;
      acc    <= acc_next;
      kp     <= kp_next;
      kf     <= kf_next;
    end
  end

endmodule

// ===== hw/rtl/hdcl_fifo.sv =====
`timescale 1ns / 1ps

module hdcl_fifo #(
  parameter int DEPTH = hdcl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hdcl_pkg::ev_t push_ev,
  input  logic          pop,
  output hdcl_pkg::ev_t head_ev,
  output logic          full,
  output logic          empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hdcl_pkg::ev_t  mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_ev = mem[rd_ptr];

  // event storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_ev;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/hdcl_back.sv =====
`timescale 1ns / 1ps

module hdcl_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  hdcl_pkg::ev_t head_ev,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    kind,
  output logic [7:0]    data_byte,
  output logic [3:0]    byte_index,
  output logic [3:0]    frame_len,
  output logic          last
);

  logic       load;
  logic       pend;
  logic [1:0] pend_kind;
  logic [3:0] pend_len;

  // output register frees up when empty or taken
  assign load = !out_valid || !out_stall;
  assign pop  = load && !pend && !q_empty;

  // control: output valid and pending line report
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        pend      <= head_ev.has_data && head_ev.has_line;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: data word first, line report after it
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        kind       <= pend_kind;
        data_byte  <= 8'd0;
        byte_index <= 4'd0;
        frame_len  <= pend_len;
        last       <= 1'b1;
      end else if (!q_empty) begin
        if (head_ev.has_data) begin
          kind       <= hdcl_pkg::KIND_DATA;
          data_byte  <= head_ev.data_byte;
          byte_index <= head_ev.byte_index;
          frame_len  <= 4'd0;
          last       <= !head_ev.has_line;
        end else begin
          kind       <= head_ev.line_kind;
          data_byte  <= 8'd0;
          byte_index <= 4'd0;
          frame_len  <= head_ev.frame_len;
          last       <= 1'b1;
        end
        pend_kind <= head_ev.line_kind;
        pend_len  <= head_ev.frame_len;
      end
    end
  end

endmodule

// ===== hw/rtl/hex_data_command_line_parser.sv =====
`timescale 1ns / 1ps
// Line parser for hex data commands, one received character per word.
// Input channel: in_valid / in_stall with rx_byte. 0x0A ends a line, 0x20
// separates tokens. A line whose first token contains DATA yields one
// result word per later token up to MAX_TOKENS (kind 0, its hex byte and
// index); every line ends with a report word: kind 1 with frame_len, or kind 2 if ignored.
// Output channel: out_valid / out_stall with kind, data_byte, byte_index,
// frame_len and last; last marks the final word caused by one character.
// Throughput: one character per cycle while the queue is not full. A
// character that ends a data token with a newline yields two words; the
// event queue between the classifier and the output stage absorbs this.
// With the queue empty, a character's first result word is written into
// the queue storage and then registered in the output stage.
// While the receiver stalls, the output word holds and the queue fills;
// in_stall rises once the queue (QUEUE_DEPTH events) is full.
// Reset clears the line state, the queue and the output valid.
module hex_data_command_line_parser #(
  parameter int MAX_TOKENS  = hdcl_pkg::MAX_TOKENS_DEF,
  parameter int QUEUE_DEPTH = hdcl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [3:0] byte_index,
  output logic [3:0] frame_len,
  output logic       last
);

  logic          push;
  hdcl_pkg::ev_t push_ev;
  logic          pop;
  hdcl_pkg::ev_t head_ev;
  logic          q_full;
  logic          q_empty;

  // classifier
  hdcl_front #(
    .MAX_TOKENS(MAX_TOKENS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (push),
    .push_ev  (push_ev)
  );

  // event queue
  hdcl_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_ev (push_ev),
    .pop     (pop),
    .head_ev (head_ev),
    .full    (q_full),
    .empty   (q_empty)
  );

  // result output stage
  hdcl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head_ev    (head_ev),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .data_byte  (data_byte),
    .byte_index (byte_index),
    .frame_len  (frame_len),
    .last       (last)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_CHARS = 1300;
  localparam int STEADY_CHARS = 350;
  localparam int HOLD_CYCLES  = 200;

  // one result word as seen on the output channel
  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] index;
    logic [3:0] len;
    logic       last;
  } result_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [3:0] byte_index;
  logic [3:0] frame_len;
  logic       last;

  result_word_t expected_words[$];
  int           errors = 0;
  int           chars_sent = 0;
  int           cycles = 0;
  int           hold_len = 0;
  bit           idle_on = 1'b1;

  // line decoder state mirrored in the testbench
  logic [3:0] tok_cnt;
  logic       in_tok;
  logic [1:0] chr_pos;
  logic [7:0] hex_acc;
  logic [2:0] kw_prog;
  logic       kw_hit;

  hex_data_command_line_parser uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .data_byte(data_byte),
    .byte_index(byte_index),
    .frame_len(frame_len),
    .last(last)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // cycle limit
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[hex_data_command_line_parser] ERROR");
        $finish;
      end
    end
  end

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= "0" && c <= "9") v = 4'(c - "0");
    else if (c >= "A" && c <= "F") v = 4'(c - 8'd55);
    else if (c >= "a" && c <= "f") v = 4'(c - 8'd87);
    return v;
  endfunction

  function automatic logic [7:0] keyword_char(input logic [1:0] p);
    logic [7:0] ch;
    case (p)
      2'd0: ch = hdcl_pkg::CH_D;
      2'd1: ch = hdcl_pkg::CH_A;
      2'd2: ch = hdcl_pkg::CH_T;
      default: ch = hdcl_pkg::CH_A;
    endcase
    return ch;
  endfunction

  task automatic clear_line_state();
    tok_cnt = 4'd0;
    in_tok  = 1'b0;
    chr_pos = 2'd0;
    hex_acc = 8'd0;
    kw_prog = 3'd0;
    kw_hit  = 1'b0;
  endtask

  // advance the line state by one character and queue the words it yields
  task automatic decode_char(input logic [7:0] c);
    result_word_t w[2];
    int           n;
    n = 0;
    if (c == hdcl_pkg::CH_NEWLINE || c == hdcl_pkg::CH_SPACE) begin
      if (in_tok) begin
        if (kw_hit && tok_cnt >= 4'd2) begin
          w[n] = '{hdcl_pkg::KIND_DATA, hex_acc, 4'(tok_cnt - 4'd2), 4'd0, 1'b0};
          n++;
        end
        in_tok = 1'b0;
      end
      if (c == hdcl_pkg::CH_NEWLINE) begin
        if (kw_hit && tok_cnt >= 4'd1)
          w[n] = '{hdcl_pkg::KIND_ACCEPT, 8'd0, 4'd0, 4'(tok_cnt - 4'd1), 1'b0};
        else
          w[n] = '{hdcl_pkg::KIND_IGNORE, 8'd0, 4'd0, 4'd0, 1'b0};
        n++;
        clear_line_state();
      end
    end else begin
      if (!in_tok && tok_cnt < hdcl_pkg::MAX_TOKENS_DEF) begin
        tok_cnt = tok_cnt + 4'd1;
        in_tok  = 1'b1;
        chr_pos = 2'd0;
        hex_acc = 8'd0;
      end
      if (in_tok) begin
        if (tok_cnt == 4'd1) begin
          // keyword search inside the first token only
          if (!kw_hit) begin
            if (c == keyword_char(kw_prog[1:0])) kw_prog = {1'b0, kw_prog[1:0]} + 3'd1;
            else kw_prog = (c == hdcl_pkg::CH_D) ? 3'd1 : 3'd0;
            if (kw_prog >= hdcl_pkg::KW_DONE) begin
              kw_hit  = 1'b1;
              kw_prog = hdcl_pkg::KW_DONE;
            end
          end
        end else begin
          if (chr_pos == 2'd0) hex_acc = {hex_value(c), 4'd0};
          else if (chr_pos == 2'd1) hex_acc = {hex_acc[7:4], hex_value(c)};
        end
        if (chr_pos < 2'd2) chr_pos = chr_pos + 2'd1;
      end
    end
    if (n > 0) w[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_words.push_back(w[i]);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // output checker
  initial begin
    result_word_t w;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, kind", kind, -1);
        end else begin
          w = expected_words.pop_front();
          if (kind !== w.kind) report_mismatch("kind", kind, w.kind);
          if (data_byte !== w.data) report_mismatch("data_byte", data_byte, w.data);
          if (byte_index !== w.index) report_mismatch("byte_index", byte_index, w.index);
          if (frame_len !== w.len) report_mismatch("frame_len", frame_len, w.len);
          if (last !== w.last) report_mismatch("last", last, w.last);
        end
      end
    end
  end

  // receiver stall: long hold on request, else random bursts
  initial begin
    @(negedge rst);
    forever begin
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // offer one character and wait until it is taken
  task automatic send_char(input logic [7:0] c);
    if (idle_on && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= c;
    do @(posedge clk); while (in_stall);
    decode_char(c);
    chars_sent++;
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // sender pauses until every expected word has come
  task automatic wait_all_done();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_token_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == hdcl_pkg::CH_NEWLINE || c == hdcl_pkg::CH_SPACE);
    return c;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  // one random line: mostly DATA commands, some broken keywords and noise
  task automatic send_random_line();
    logic [7:0] chars[$];
    string      bad_kw[5] = '{"DAT", "DATB", "DDAT", "ATAD", "DAXTA"};
    string      s;
    int         r;
    int         ntok;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 20)) chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 7) == 0) chars.push_back(hdcl_pkg::CH_SPACE);
      if (r < 75) begin
        repeat ($urandom_range(0, 2)) chars.push_back(rand_token_char());
        s = "DATA";
        for (int i = 0; i < 4; i++) chars.push_back(s[i]);
        repeat ($urandom_range(0, 2)) chars.push_back(rand_token_char());
      end else if (r < 90) begin
        s = bad_kw[$urandom_range(0, 4)];
        for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
      end else begin
        repeat ($urandom_range(1, 5)) chars.push_back(rand_token_char());
      end
      ntok = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 13) : $urandom_range(0, 5);
      repeat (ntok) begin
        repeat ($urandom_range(1, 3)) chars.push_back(hdcl_pkg::CH_SPACE);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 4) == 0) chars.push_back(rand_token_char());
          else chars.push_back(rand_hex_char());
        end
      end
      repeat ($urandom_range(0, 2)) chars.push_back(hdcl_pkg::CH_SPACE);
      chars.push_back(hdcl_pkg::CH_NEWLINE);
    end
    foreach (chars[i]) send_char(chars[i]);
  endtask

  // extremes, short, long and non-hex tokens, keyword placement, empty lines
  task automatic test_directed();
    send_line("xDATA 00 Fg1 ");
    send_char(8'hFF);
    send_char("9");
    send_char(hdcl_pkg::CH_SPACE);
    send_char(8'h00);
    send_char(hdcl_pkg::CH_NEWLINE);
    send_line("\n");
    send_line(" A  DATA \n");
    send_line("DADATA e\n");
    send_line("DATA\n");
    wait_all_done();
  endtask

  // more tokens than the line may count
  task automatic test_token_limit();
    send_line("DATA 1 2 3 4 5 6 7 8 9 a b\n");
    wait_all_done();
  endtask

  task automatic test_random();
    int target;
    target = chars_sent + RANDOM_CHARS;
    while (chars_sent < target) send_random_line();
    wait_all_done();
  endtask

  // receiver holds off while the sender keeps offering, queue fills
  task automatic test_backpressure();
    hold_len = HOLD_CYCLES;
    repeat (4) send_line("DATA 12 34 56 78 9a bc\n");
    wait_all_done();
    repeat (3) send_random_line();
    wait_all_done();
  endtask

  // last stretch runs with no idling on either side
  task automatic test_steady();
    int target;
    idle_on = 1'b0;
    target = chars_sent + STEADY_CHARS;
    while (chars_sent < target) send_random_line();
    wait_all_done();
  endtask

  initial begin
    clear_line_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_token_limit();
    test_random();
    test_backpressure();
    test_steady();
    if (errors == 0) begin
      $display("[hex_data_command_line_parser] OK");
    end else begin
      $display("[hex_data_command_line_parser] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hdcl_pkg.sv
hw/rtl/hdcl_front.sv
hw/rtl/hdcl_fifo.sv
hw/rtl/hdcl_back.sv
hw/rtl/hex_data_command_line_parser.sv
tb/testbench.sv
